// ===== hdl/brfd_pkg.sv =====
// ----------------------------------------------------------------------------
// brfd_pkg
// Shared types and constants for the byte ring FIFO with discard.
// ----------------------------------------------------------------------------
package brfd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int CNT_W     = 7;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 3;
    localparam int ST_W      = 2;
    localparam int ALU_W     = 8;

    localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RD_EXACT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RD_UPTO  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DISC_HD  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DISC_TL  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_BURST    = 3'd6;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } alu_rsp_t;

endpackage

// ===== hdl/brfd_ram.sv =====
// ----------------------------------------------------------------------------
// brfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/brfd_alu.sv =====
// ----------------------------------------------------------------------------
// brfd_alu
// Shared add/subtract unit: all length compares and the discard position moves use it.
// ----------------------------------------------------------------------------
module brfd_alu (
    input  brfd_pkg::alu_req_t req,
    output brfd_pkg::alu_rsp_t rsp
);

    logic [brfd_pkg::ALU_W:0] sum;

    always_comb
    begin
        if (req.sub)
        begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res    = sum[brfd_pkg::ALU_W-1:0];
        // borrow on subtract means b > a
        rsp.borrow = req.sub & sum[brfd_pkg::ALU_W];
    end

endmodule

// ===== hdl/byte_ring_fifo_with_discard_core.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_discard_core
// Byte FIFO in a power-of-two ring with read, discard and burst write actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one action per transaction:
//   push, pop, read exact, read up to, discard head/tail, burst write byte.
//   Output channel (out_valid/out_ready) returns one result per byte read,
//   or one result for any other action; last marks the final result.
//   Every result carries status and the fill/free counts after it.
// Sequencing:
//   in_ready is high only while the sequencer is idle. An item that reads
//   no byte goes from the check state to the response state, which loads
//   the output register; an in-range discard passes the adjust state between,
//   where the shared adder moves a position, and a burst item the burst state.
//   A read passes the check state, then an issue and a wait state per byte,
//   set by the single registered RAM read port feeding the output register.
// Stall:
//   A result waits in the output register while out_ready is low; the
//   sequencer holds until that register is free again.
// Reset:
//   rst_n clears positions, counts and burst state; the RAM is not cleared
//   and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_discard_core #(
    parameter int DEPTH = brfd_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [brfd_pkg::ACT_W-1:0]    action,
    input  logic [brfd_pkg::BYTE_W-1:0]   data_byte,
    input  logic [brfd_pkg::LEN_W-1:0]    length,
    input  logic                          burst_first,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [brfd_pkg::BYTE_W-1:0]   read_byte,
    output logic [brfd_pkg::ST_W-1:0]     status,
    output logic [brfd_pkg::CNT_W-1:0]    fill_count,
    output logic [brfd_pkg::CNT_W-1:0]    free_count,
    output logic                          last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = brfd_pkg::CNT_W;
    localparam int AW    = brfd_pkg::ALU_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_BURST    = 3'd2;
    localparam logic [2:0] S_ADJ      = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;
    localparam logic [2:0] S_RD_ISSUE = 3'd5;
    localparam logic [2:0] S_RD_WAIT  = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [PTR_W-1:0]            rd_pos_reg, rd_pos_next;
    logic [PTR_W-1:0]            wr_pos_reg, wr_pos_next;
    logic [CW-1:0]               held_reg, held_next;
    logic [brfd_pkg::LEN_W-1:0]  left_reg, left_next;
    logic                        acc_reg, acc_next;
    logic [brfd_pkg::ACT_W-1:0]  act_reg, act_next;
    logic [brfd_pkg::BYTE_W-1:0] data_reg, data_next;
    logic [brfd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        first_reg, first_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [brfd_pkg::ST_W-1:0]   st_reg, st_next;

    logic                        ov_reg, ov_next;
    logic [brfd_pkg::BYTE_W-1:0] ob_reg, ob_next;
    logic [brfd_pkg::ST_W-1:0]   os_reg, os_next;
    logic [CW-1:0]               of_reg, of_next;
    logic                        ol_reg, ol_next;

    brfd_pkg::alu_req_t          alu_req;
    brfd_pkg::alu_rsp_t          alu_rsp;

    logic                        ram_we;
    logic                        ram_re;
    logic [brfd_pkg::BYTE_W-1:0] ram_rdata;

    logic                        in_acc;
    logic                        slot_free;
    logic                        full;
    logic [CW-1:0]               free_cnt;
    logic [CW-1:0]               held_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid & in_ready;
    assign slot_free = ~ov_reg | out_ready;
    assign full      = (held_reg == DEPTH_C);
    assign free_cnt  = DEPTH_C - held_reg;
    assign held_dec  = held_reg - CW'(1);

    brfd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    brfd_ram #(
        .WIDTH (brfd_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_pos_reg),
        .wdata (data_reg),
        .re    (ram_re),
        .raddr (rd_pos_reg),
        .rdata (ram_rdata)
    );

    // operand select for the shared adder
    always_comb
    begin
        alu_req.a   = AW'(held_reg);
        alu_req.b   = AW'(len_reg);
        alu_req.sub = 1'b1;
        case (state_reg)
            S_CHECK:
            begin
                if (act_reg == brfd_pkg::ACT_BURST)
                begin
                    alu_req.a = AW'(free_cnt);
                end
            end
            S_ADJ:
            begin
                if (act_reg == brfd_pkg::ACT_DISC_HD)
                begin
                    alu_req.a   = AW'(rd_pos_reg);
                    alu_req.sub = 1'b0;
                end
                else
                begin
                    alu_req.a = AW'(wr_pos_reg);
                end
            end
            default:
            begin
                alu_req.a = AW'(held_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_pos_next = rd_pos_reg;
        wr_pos_next = wr_pos_reg;
        held_next   = held_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        act_next    = act_reg;
        data_next   = data_reg;
        len_next    = len_reg;
        first_next  = first_reg;
        n_next      = n_reg;
        st_next     = st_reg;
        ov_next     = ov_reg & ~out_ready;
        ob_next     = ob_reg;
        os_next     = os_reg;
        of_next     = of_reg;
        ol_next     = ol_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    act_next   = action;
                    data_next  = data_byte;
                    len_next   = length;
                    first_next = burst_first;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_RESP;
                st_next    = brfd_pkg::ST_OK;
                case (act_reg)
                    brfd_pkg::ACT_PUSH:
                    begin
                        if (full)
                        begin
                            st_next = brfd_pkg::ST_NOSPACE;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            wr_pos_next = wr_pos_reg + PTR_W'(1);
                            held_next   = held_reg + CW'(1);
                        end
                    end
                    brfd_pkg::ACT_POP:
                    begin
                        if (held_reg != '0)
                        begin
                            n_next     = CW'(1);
                            state_next = S_RD_ISSUE;
                        end
                    end
                    brfd_pkg::ACT_RD_EXACT:
                    begin
                        if (alu_rsp.borrow)
                        begin
                            st_next = brfd_pkg::ST_RANGE;
                        end
                        else if (len_reg != '0)
                        begin
                            n_next     = CW'(len_reg);
                            state_next = S_RD_ISSUE;
                        end
                    end
                    brfd_pkg::ACT_RD_UPTO:
                    begin
                        if (alu_rsp.borrow)
                        begin
                            n_next = held_reg;
                            if (held_reg != '0)
                            begin
                                state_next = S_RD_ISSUE;
                            end
                        end
                        else
                        begin
                            n_next = CW'(len_reg);
                            if (len_reg != '0)
                            begin
                                state_next = S_RD_ISSUE;
                            end
                        end
                    end
                    brfd_pkg::ACT_DISC_HD, brfd_pkg::ACT_DISC_TL:
                    begin
                        if (alu_rsp.borrow)
                        begin
                            st_next = brfd_pkg::ST_RANGE;
                        end
                        else
                        begin
                            held_next  = alu_rsp.res[CW-1:0];
                            state_next = S_ADJ;
                        end
                    end
                    brfd_pkg::ACT_BURST:
                    begin
                        if (first_reg)
                        begin
                            left_next = len_reg;
                            acc_next  = ~alu_rsp.borrow;
                        end
                        state_next = S_BURST;
                    end
                    default:
                    begin
                        st_next = brfd_pkg::ST_RANGE;
                    end
                endcase
            end
            S_BURST:
            begin
                state_next = S_RESP;
                if (first_reg && !acc_reg)
                begin
                    // rejected burst: first byte still counts against the length
                    if (left_reg != '0)
                    begin
                        left_next = left_reg - brfd_pkg::LEN_W'(1);
                    end
                    st_next = brfd_pkg::ST_NOSPACE;
                end
                else if (first_reg && left_reg == '0)
                begin
                    st_next = brfd_pkg::ST_OK;
                end
                else if (left_reg == '0)
                begin
                    st_next = brfd_pkg::ST_RANGE;
                end
                else
                begin
                    left_next = left_reg - brfd_pkg::LEN_W'(1);
                    if (acc_reg && !full)
                    begin
                        ram_we      = 1'b1;
                        wr_pos_next = wr_pos_reg + PTR_W'(1);
                        held_next   = held_reg + CW'(1);
                        st_next     = brfd_pkg::ST_OK;
                    end
                    else
                    begin
                        st_next = brfd_pkg::ST_NOSPACE;
                    end
                end
            end
            S_ADJ:
            begin
                if (act_reg == brfd_pkg::ACT_DISC_HD)
                begin
                    rd_pos_next = alu_rsp.res[PTR_W-1:0];
                end
                else
                begin
                    wr_pos_next = alu_rsp.res[PTR_W-1:0];
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = '0;
                    os_next    = st_reg;
                    of_next    = held_reg;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                ram_re     = 1'b1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                if (slot_free)
                begin
                    ov_next     = 1'b1;
                    ob_next     = ram_rdata;
                    os_next     = brfd_pkg::ST_OK;
                    of_next     = held_dec;
                    ol_next     = (n_reg == CW'(1));
                    rd_pos_next = rd_pos_reg + PTR_W'(1);
                    held_next   = held_dec;
                    n_next      = n_reg - CW'(1);
                    state_next  = (n_reg == CW'(1)) ? S_IDLE : S_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_pos_reg <= '0;
            wr_pos_reg <= '0;
            held_reg   <= '0;
            left_reg   <= '0;
            acc_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_pos_reg <= rd_pos_next;
            wr_pos_reg <= wr_pos_next;
            held_reg   <= held_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        data_reg  <= data_next;
        len_reg   <= len_next;
        first_reg <= first_next;
        n_reg     <= n_next;
        st_reg    <= st_next;
        ob_reg    <= ob_next;
        os_reg    <= os_next;
        of_reg    <= of_next;
        ol_reg    <= ol_next;
    end

    assign out_valid  = ov_reg;
    assign read_byte  = ob_reg;
    assign status     = os_reg;
    assign fill_count = of_reg;
    assign free_count = DEPTH_C - of_reg;
    assign last       = ol_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= DEPTH_C)
        else $error("held count above ring depth");

    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            (PTR_W'(rd_pos_reg + held_reg[PTR_W-1:0]) == wr_pos_reg))
        else $error("read position plus held count does not reach write position");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("sequencer ready right after taking an item");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CW'(fill_count + free_count) == DEPTH_C))
        else $error("fill and free counts do not add up to depth");

    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
        else $error("RAM read and write issued in the same cycle");
`endif

endmodule

// ===== bench/tb_byte_ring_fifo_with_discard_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_discard_core
// Drives actions into the byte ring FIFO and checks every result against a
// behavioral ring model kept in the bench: a directed table first, then
// random traffic of burst writes and other actions with one fill and drain,
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_discard_core;

    localparam int RING_DEPTH     = brfd_pkg::DEPTH_DEF;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int RANDOM_ITEMS   = 94;
    localparam int HOLD_OFF       = 300;
    localparam int HOLD_AFTER     = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_RUN_CYCLES = 200000;

    localparam logic [brfd_pkg::ACT_W-1:0] ACT_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [brfd_pkg::BYTE_W-1:0] rbyte;
        logic [brfd_pkg::ST_W-1:0]   st;
        logic [brfd_pkg::CNT_W-1:0]  fill;
        logic [brfd_pkg::CNT_W-1:0]  free;
        logic                        lst;
    } fifo_result_t;

    typedef struct {
        logic [brfd_pkg::ACT_W-1:0]  act;
        logic [brfd_pkg::BYTE_W-1:0] data;
        logic [brfd_pkg::LEN_W-1:0]  len;
        logic                        first;
        bit                          chk;
        logic [brfd_pkg::BYTE_W-1:0] exp_byte;
        logic [brfd_pkg::ST_W-1:0]   exp_st;
        int                          exp_fill;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [brfd_pkg::ACT_W-1:0]  action;
    logic [brfd_pkg::BYTE_W-1:0] data_byte;
    logic [brfd_pkg::LEN_W-1:0]  length;
    logic                        burst_first;
    logic out_valid;
    logic out_ready;
    logic [brfd_pkg::BYTE_W-1:0] read_byte;
    logic [brfd_pkg::ST_W-1:0]   status;
    logic [brfd_pkg::CNT_W-1:0]  fill_count;
    logic [brfd_pkg::CNT_W-1:0]  free_count;
    logic                        last;

    // ring model state
    logic [brfd_pkg::BYTE_W-1:0] ring_mem [RING_DEPTH];
    int ring_rd_pos   = 0;
    int ring_wr_pos   = 0;
    int ring_held     = 0;
    int burst_left    = 0;
    bit burst_ok      = 1'b0;

    fifo_result_t pending_fifo_results[$];
    stim_row_t    directed_rows[$];

    int  fail_count   = 0;
    int  items_sent   = 0;
    int  idle_cycles  = 0;
    int  run_cycles   = 0;
    bit  sender_steady = 1'b0;

    byte_ring_fifo_with_discard_core #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .data_byte  (data_byte),
        .length     (length),
        .burst_first(burst_first),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_byte  (read_byte),
        .status     (status),
        .fill_count (fill_count),
        .free_count (free_count),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------------
    function automatic void note_result(logic [brfd_pkg::BYTE_W-1:0] b,
                                        logic [brfd_pkg::ST_W-1:0] st, logic lst);
        fifo_result_t r;
        r.rbyte = b;
        r.st    = st;
        r.fill  = brfd_pkg::CNT_W'(ring_held);
        r.free  = brfd_pkg::CNT_W'(RING_DEPTH - ring_held);
        r.lst   = lst;
        pending_fifo_results.push_back(r);
    endfunction

    function automatic bit ring_store(logic [brfd_pkg::BYTE_W-1:0] b);
        if (ring_held >= RING_DEPTH)
            return 1'b0;
        ring_mem[ring_wr_pos[PTR_W-1:0]] = b;
        ring_wr_pos = (ring_wr_pos + 1) % RING_DEPTH;
        ring_held++;
        return 1'b1;
    endfunction

    // oldest byte first, one result per byte
    function automatic void ring_take(int n);
        logic [brfd_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = ring_mem[ring_rd_pos[PTR_W-1:0]];
            ring_rd_pos = (ring_rd_pos + 1) % RING_DEPTH;
            ring_held--;
            note_result(b, brfd_pkg::ST_OK, i == n - 1);
        end
    endfunction

    function automatic void predict_fifo_results(logic [brfd_pkg::ACT_W-1:0] act,
                                                 logic [brfd_pkg::BYTE_W-1:0] data,
                                                 logic [brfd_pkg::LEN_W-1:0] len_f,
                                                 logic first);
        int len;
        int n;
        logic [brfd_pkg::ST_W-1:0] st;
        len = int'(len_f);
        case (act)
            brfd_pkg::ACT_PUSH:
            begin
                st = ring_store(data) ? brfd_pkg::ST_OK : brfd_pkg::ST_NOSPACE;
                note_result('0, st, 1'b1);
            end
            brfd_pkg::ACT_POP:
            begin
                if (ring_held == 0)
                    note_result('0, brfd_pkg::ST_OK, 1'b1);
                else
                    ring_take(1);
            end
            brfd_pkg::ACT_RD_EXACT:
            begin
                if (len > ring_held)
                    note_result('0, brfd_pkg::ST_RANGE, 1'b1);
                else if (len == 0)
                    note_result('0, brfd_pkg::ST_OK, 1'b1);
                else
                    ring_take(len);
            end
            brfd_pkg::ACT_RD_UPTO:
            begin
                n = (len < ring_held) ? len : ring_held;
                if (n == 0)
                    note_result('0, brfd_pkg::ST_OK, 1'b1);
                else
                    ring_take(n);
            end
            brfd_pkg::ACT_DISC_HD:
            begin
                if (len > ring_held)
                    st = brfd_pkg::ST_RANGE;
                else
                begin
                    ring_rd_pos = (ring_rd_pos + len) % RING_DEPTH;
                    ring_held -= len;
                    st = brfd_pkg::ST_OK;
                end
                note_result('0, st, 1'b1);
            end
            brfd_pkg::ACT_DISC_TL:
            begin
                if (len > ring_held)
                    st = brfd_pkg::ST_RANGE;
                else
                begin
                    ring_wr_pos = (ring_wr_pos + RING_DEPTH - len) % RING_DEPTH;
                    ring_held -= len;
                    st = brfd_pkg::ST_OK;
                end
                note_result('0, st, 1'b1);
            end
            brfd_pkg::ACT_BURST:
            begin
                if (first)
                begin
                    burst_left = len;
                    burst_ok   = (RING_DEPTH - ring_held) >= len;
                    if (!burst_ok)
                    begin
                        // rejected burst still consumes its first byte
                        if (burst_left > 0)
                            burst_left--;
                        note_result('0, brfd_pkg::ST_NOSPACE, 1'b1);
                        return;
                    end
                    if (len == 0)
                    begin
                        note_result('0, brfd_pkg::ST_OK, 1'b1);
                        return;
                    end
                end
                if (burst_left == 0)
                begin
                    note_result('0, brfd_pkg::ST_RANGE, 1'b1);
                    return;
                end
                burst_left--;
                st = brfd_pkg::ST_NOSPACE;
                if (burst_ok)
                    st = ring_store(data) ? brfd_pkg::ST_OK : brfd_pkg::ST_NOSPACE;
                note_result('0, st, 1'b1);
            end
            default:
                note_result('0, brfd_pkg::ST_RANGE, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        fifo_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_fifo_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual byte %0h status %0h",
                         $time, read_byte, status);
                fail_count++;
            end
            else
            begin
                want = pending_fifo_results.pop_front();
                check_field("read_byte", want.rbyte, read_byte);
                check_field("status", 8'(want.st), 8'(status));
                check_field("fill_count", 8'(want.fill), 8'(fill_count));
                check_field("free_count", 8'(want.free), 8'(free_count));
                check_field("last", 8'(want.lst), 8'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            run_cycles++;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT || run_cycles >= MAX_RUN_CYCLES)
            begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         pending_fifo_results.size());
                $display("tb_byte_ring_fifo_with_discard_core NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stalls, steady stretches, one long hold-off
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    initial
    begin : output_side
        int stall_left;
        int taken;
        int mode_cycles;
        bit steady;
        bit held_off;
        stall_left  = 0;
        taken       = 0;
        mode_cycles = 0;
        steady      = 1'b0;
        held_off    = 1'b0;
        out_ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                taken++;
            if (++mode_cycles == 150)
            begin
                mode_cycles = 0;
                steady = ($urandom_range(0, 3) == 0);
            end
            if (!held_off && taken >= HOLD_AFTER)
            begin
                // sender keeps offering while results back up
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_item(input stim_row_t row);
        int gap;
        fifo_result_t typed;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= row.act;
        data_byte   <= row.data;
        length      <= row.len;
        burst_first <= row.first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_fifo_results(row.act, row.data, row.len, row.first);
        if (row.chk)
        begin
            typed.rbyte = row.exp_byte;
            typed.st    = row.exp_st;
            typed.fill  = brfd_pkg::CNT_W'(row.exp_fill);
            typed.free  = brfd_pkg::CNT_W'(RING_DEPTH - row.exp_fill);
            typed.lst   = 1'b1;
            pending_fifo_results[pending_fifo_results.size() - 1] = typed;
        end
        if (row.act != ACT_UNKNOWN)
            items_sent++;
    endtask

    task automatic send_op(input logic [brfd_pkg::ACT_W-1:0] act, input int data,
                           input int len, input bit first);
        stim_row_t row;
        row.act      = act;
        row.data     = brfd_pkg::BYTE_W'(data);
        row.len      = brfd_pkg::LEN_W'(len);
        row.first    = first;
        row.chk      = 1'b0;
        row.exp_byte = '0;
        row.exp_st   = brfd_pkg::ST_OK;
        row.exp_fill = 0;
        send_item(row);
    endtask

    function automatic void add_row(logic [brfd_pkg::ACT_W-1:0] act, int data, int len,
                                    bit first, bit chk, int exp_byte,
                                    logic [brfd_pkg::ST_W-1:0] exp_st, int exp_fill);
        stim_row_t row;
        row.act      = act;
        row.data     = brfd_pkg::BYTE_W'(data);
        row.len      = brfd_pkg::LEN_W'(len);
        row.first    = first;
        row.chk      = chk;
        row.exp_byte = brfd_pkg::BYTE_W'(exp_byte);
        row.exp_st   = exp_st;
        row.exp_fill = exp_fill;
        directed_rows.push_back(row);
    endfunction

    task automatic random_op();
        int r;
        int len;
        logic [brfd_pkg::ACT_W-1:0] act;
        r = $urandom_range(0, 99);
        if (r < 3)
            act = ACT_UNKNOWN;
        else if (r < 6)
            act = brfd_pkg::ACT_BURST;
        else if (r < 32)
            act = brfd_pkg::ACT_PUSH;
        else
            act = brfd_pkg::ACT_W'($urandom_range(1, 5));
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(0, ring_held + 2);
        else if (r < 85)
            len = ring_held;
        else
            len = $urandom_range(0, 127);
        send_op(act, $urandom_range(0, 255), len,
                (act == brfd_pkg::ACT_BURST) ? 1'b0 : 1'($urandom_range(0, 1)));
    endtask

    // one burst, with other actions slipped in, early aborts and stray bytes
    task automatic random_burst();
        int free_now;
        int blen;
        int follow;
        int r;
        free_now = RING_DEPTH - ring_held;
        r = $urandom_range(0, 99);
        if (r < 70)
            blen = $urandom_range(0, (free_now < 12) ? free_now : 12);
        else if (r < 80)
            blen = free_now;
        else
            blen = $urandom_range(free_now + 1, 127);
        follow = (blen > 0) ? blen - 1 : 0;
        if (blen > free_now && follow > 6)
            follow = $urandom_range(0, 6);
        send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), blen, 1'b1);
        for (int i = 0; i < follow; i++)
        begin
            if ($urandom_range(0, 99) < 12)
                random_op();
            if ($urandom_range(0, 99) < 4)
                break;
            send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), $urandom_range(0, 127),
                    1'b0);
        end
        if ($urandom_range(0, 99) < 5)
            send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), $urandom_range(0, 127),
                    1'b0);
    endtask

    // burst sized to the free space, two pushes in the middle steal its room,
    // so the tail of the burst meets a full ring; then drain it all
    task automatic fill_ring_completely();
        int blen;
        int half;
        blen = RING_DEPTH - ring_held;
        half = blen / 2;
        send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), blen, 1'b1);
        for (int i = 1; i < blen; i++)
        begin
            if (i == half)
            begin
                send_op(brfd_pkg::ACT_PUSH, $urandom_range(0, 255), 0, 1'b0);
                send_op(brfd_pkg::ACT_PUSH, $urandom_range(0, 255), 0, 1'b0);
            end
            send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), $urandom_range(0, 127),
                    1'b0);
        end
        send_op(brfd_pkg::ACT_PUSH, $urandom_range(0, 255), 0, 1'b0);
        send_op(brfd_pkg::ACT_BURST, $urandom_range(0, 255), 1, 1'b1);
        send_op(brfd_pkg::ACT_RD_EXACT, 0, RING_DEPTH, 1'b0);
    endtask

    initial
    begin : input_side
        int random_start;
        bit fill_done;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = brfd_pkg::ACT_PUSH;
        data_byte   = '0;
        length      = '0;
        burst_first = 1'b0;
        fill_done   = 1'b0;

        // empty ring corner cases
        add_row(brfd_pkg::ACT_POP,      0,   0,   0, 1, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_RD_EXACT, 0,   0,   0, 1, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_RD_EXACT, 0,   1,   0, 1, 0,   brfd_pkg::ST_RANGE,   0);
        add_row(brfd_pkg::ACT_RD_UPTO,  0,   127, 0, 1, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_DISC_HD,  0,   1,   0, 1, 0,   brfd_pkg::ST_RANGE,   0);
        add_row(brfd_pkg::ACT_DISC_TL,  0,   127, 0, 1, 0,   brfd_pkg::ST_RANGE,   0);
        add_row(ACT_UNKNOWN,            255, 127, 1, 1, 0,   brfd_pkg::ST_RANGE,   0);
        add_row(brfd_pkg::ACT_BURST,    0,   0,   0, 1, 0,   brfd_pkg::ST_RANGE,   0);
        // byte extremes through push and reads
        add_row(brfd_pkg::ACT_PUSH,     0,   0,   1, 1, 0,   brfd_pkg::ST_OK,      1);
        add_row(brfd_pkg::ACT_PUSH,     255, 0,   0, 1, 0,   brfd_pkg::ST_OK,      2);
        add_row(brfd_pkg::ACT_PUSH,     165, 0,   0, 1, 0,   brfd_pkg::ST_OK,      3);
        add_row(brfd_pkg::ACT_RD_EXACT, 0,   2,   0, 0, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_POP,      0,   0,   0, 1, 165, brfd_pkg::ST_OK,      0);
        // rejected burst, zero length burst, stray byte
        add_row(brfd_pkg::ACT_BURST,    90,  127, 1, 1, 0,   brfd_pkg::ST_NOSPACE, 0);
        add_row(brfd_pkg::ACT_BURST,    17,  0,   0, 1, 0,   brfd_pkg::ST_NOSPACE, 0);
        add_row(brfd_pkg::ACT_BURST,    0,   0,   1, 1, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_BURST,    0,   0,   0, 1, 0,   brfd_pkg::ST_RANGE,   0);
        // accepted burst with a push slipped in
        add_row(brfd_pkg::ACT_BURST,    16,  3,   1, 1, 0,   brfd_pkg::ST_OK,      1);
        add_row(brfd_pkg::ACT_PUSH,     32,  0,   0, 1, 0,   brfd_pkg::ST_OK,      2);
        add_row(brfd_pkg::ACT_BURST,    17,  0,   0, 1, 0,   brfd_pkg::ST_OK,      3);
        add_row(brfd_pkg::ACT_BURST,    18,  0,   0, 1, 0,   brfd_pkg::ST_OK,      4);
        add_row(brfd_pkg::ACT_BURST,    19,  0,   0, 1, 0,   brfd_pkg::ST_RANGE,   4);
        add_row(brfd_pkg::ACT_DISC_TL,  0,   1,   0, 1, 0,   brfd_pkg::ST_OK,      3);
        add_row(brfd_pkg::ACT_DISC_HD,  0,   64,  0, 1, 0,   brfd_pkg::ST_RANGE,   3);
        add_row(brfd_pkg::ACT_RD_UPTO,  0,   64,  0, 0, 0,   brfd_pkg::ST_OK,      0);
        add_row(brfd_pkg::ACT_DISC_HD,  0,   0,   0, 1, 0,   brfd_pkg::ST_OK,      0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            sender_steady = ($urandom_range(0, 4) == 0);
            if (!fill_done && items_sent - random_start >= 30)
            begin
                fill_ring_completely();
                fill_done = 1'b1;
            end
            else if ($urandom_range(0, 99) < 40)
                random_burst();
            else
                random_op();
        end
        in_valid <= 1'b0;

        while (pending_fifo_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_byte_ring_fifo_with_discard_core OK");
        else
            $display("tb_byte_ring_fifo_with_discard_core NOT OK");
        $finish;
    end

endmodule
